// ----- rtl/core/ptrg_pkg.sv -----
// Shared types and constants for the pre-trade risk gate.
package ptrg_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_ORDER     = 2'd0,
        KIND_FILL      = 2'd1,
        KIND_MID       = 2'd2,
        KIND_SOFT_RST  = 2'd3
    } kind_t;

    // Order check outcome
    typedef enum logic [2:0] {
        REASON_OK       = 3'd0,
        REASON_KILL     = 3'd1,
        REASON_INVALID  = 3'd2,
        REASON_RATE     = 3'd3,
        REASON_NOTIONAL = 3'd4,
        REASON_BAND     = 3'd5
    } reason_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_NOTIONAL  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_BPS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_POSITION  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KILL_AT_START = 3'd4;

    localparam int CFG_DATA_W = 63;

    // Field widths
    localparam int RATE_W     = 20;
    localparam int NOTIONAL_W = 63;
    localparam int BPS_W      = 14;
    localparam int MAXPOS_W   = 48;
    localparam int TS_W       = 63;
    localparam int PX_W       = 32;
    localparam int POS_W      = 64;
    localparam int TOKEN_W    = 50;
    localparam int DT_W       = 30;

    // One order's worth of tokens, also the largest useful refill interval
    localparam logic [DT_W-1:0]    TOKEN_UNIT    = 30'd1000000000;
    localparam logic [TOKEN_W-1:0] TOKEN_UNIT_L  = 50'd1000000000;
    localparam logic [TOKEN_W-1:0] CAP_RESET     = 50'd1000000000000;

    localparam logic [RATE_W-1:0]     MAX_RATE_RESET     = 20'd1000;
    localparam logic [NOTIONAL_W-1:0] MAX_NOTIONAL_RESET = 63'd1000000000;
    localparam logic [BPS_W-1:0]      BAND_BPS_RESET     = 14'd100;
    localparam logic [MAXPOS_W-1:0]   MAX_POSITION_RESET = 48'd1000000;

    localparam logic signed [16:0] BPS_SCALE = 17'sd10000;

    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 72;

endpackage

// ----- rtl/core/pre_trade_risk_gate_unit.sv -----
// Pre-trade risk gate: order checks, fills, reference mid and soft reset.
// A result passes through the input register, then the result register;
// all checks run in the single stage between them.
// Throughput: one item per cycle while m_tready does not stall the result register; the
// token bucket refill multiply, add and cap in the state loop set the cycle time.
// Reset (aresetn low, synchronous): registers take their default values, the
// bucket is full, position, last time, reference mid and kill latch are cleared.
module pre_trade_risk_gate_unit
    import ptrg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    // side[0], price[32:1], quantity[64:33], timestamp[127:65],
    // mid_price[159:128], mid_valid[160], zero padding above
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [1:0]              s_tuser,

    output logic                    m_tvalid,
    input  logic                    m_tready,
    // accepted[0], reason[3:1], net_position[67:4], kill_active[68], zero padding above
    output logic [OUT_TDATA_W-1:0]  m_tdata,

    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    // Configuration
    logic [RATE_W-1:0]     max_rate_reg;
    logic [NOTIONAL_W-1:0] max_notional_reg;
    logic [BPS_W-1:0]      band_bps_reg;
    logic [MAXPOS_W-1:0]   max_position_reg;
    logic                  kill_at_start_reg;
    logic [TOKEN_W-1:0]    capacity_reg;

    // Input stage
    logic                  in_vld_reg;
    kind_t                 kind_reg;
    logic                  side_reg;
    logic signed [PX_W-1:0] price_reg;
    logic signed [PX_W-1:0] qty_reg;
    logic [TS_W-1:0]       ts_reg;
    logic signed [PX_W-1:0] mid_price_reg;
    logic                  mid_valid_reg;

    // Gate state
    logic [TOKEN_W-1:0]    token_reg, token_next;
    logic [TS_W-1:0]       last_time_reg, last_time_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic signed [PX_W-1:0] ref_mid_reg, ref_mid_next;
    logic                  ref_present_reg, ref_present_next;
    logic                  kill_latched_reg, kill_latched_next;

    // Result stage
    logic                  out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    reason_t               reason_next;

    logic                  advance;
    logic                  in_xfer;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- datapath terms ----------------
    logic                  refill_en;
    logic [TS_W-1:0]       dt_full;
    logic [DT_W-1:0]       dt_cap;
    logic [TOKEN_W-1:0]    refill_amt;
    logic [TOKEN_W:0]      level_sum;
    logic [TOKEN_W-1:0]    level_capped;
    logic [61:0]           notional;
    logic signed [48:0]    px_scaled;
    logic signed [16:0]    lo_factor;
    logic signed [16:0]    hi_factor;
    logic signed [48:0]    band_lo;
    logic signed [48:0]    band_hi;
    logic signed [32:0]    fill_delta;
    logic signed [POS_W:0] pos_sum;
    logic signed [POS_W-1:0] pos_sat;
    logic [POS_W-1:0]      pos_mag;

    assign refill_en  = (last_time_reg != '0) && (ts_reg > last_time_reg);
    assign dt_full    = ts_reg - last_time_reg;
    assign dt_cap     = (dt_full > TS_W'(TOKEN_UNIT)) ? TOKEN_UNIT : dt_full[DT_W-1:0];
    assign refill_amt = TOKEN_W'(dt_cap) * TOKEN_W'(max_rate_reg);
    assign level_sum  = refill_en ? ({1'b0, token_reg} + {1'b0, refill_amt})
                                  : {1'b0, token_reg};
    // capping only applies when a refill happened
    assign level_capped = (refill_en && (level_sum > {1'b0, capacity_reg}))
                          ? capacity_reg : level_sum[TOKEN_W-1:0];

    assign notional   = 62'(price_reg[30:0]) * 62'(qty_reg[30:0]);

    assign px_scaled  = 49'(price_reg) * 49'(BPS_SCALE);
    assign lo_factor  = BPS_SCALE - $signed({3'b000, band_bps_reg});
    assign hi_factor  = BPS_SCALE + $signed({3'b000, band_bps_reg});
    assign band_lo    = 49'(ref_mid_reg) * 49'(lo_factor);
    assign band_hi    = 49'(ref_mid_reg) * 49'(hi_factor);

    assign fill_delta = side_reg ? -33'(qty_reg) : 33'(qty_reg);
    assign pos_sum    = 65'(pos_reg) + 65'(fill_delta);
    assign pos_sat    = (pos_sum[POS_W] != pos_sum[POS_W-1])
                        ? (pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                          : {1'b0, {(POS_W-1){1'b1}}})
                        : pos_sum[POS_W-1:0];
    assign pos_mag    = pos_sat[POS_W-1] ? (POS_W'(0) - pos_sat) : pos_sat;

    // ---------------- state next value ----------------
    always_comb begin
        token_next        = token_reg;
        last_time_next    = last_time_reg;
        pos_next          = pos_reg;
        ref_mid_next      = ref_mid_reg;
        ref_present_next  = ref_present_reg;
        kill_latched_next = kill_latched_reg;
        reason_next       = REASON_OK;
        case (kind_reg)
            KIND_ORDER: begin
                if (kill_at_start_reg || kill_latched_reg) begin
                    reason_next = REASON_KILL;
                end else if (qty_reg <= 0 || price_reg <= 0) begin
                    reason_next = REASON_INVALID;
                end else begin
                    last_time_next = ts_reg;
                    if (level_capped < TOKEN_UNIT_L) begin
                        token_next  = level_capped;
                        reason_next = REASON_RATE;
                    end else begin
                        // tokens are spent even if a later check rejects
                        token_next = level_capped - TOKEN_UNIT_L;
                        if ({1'b0, notional} > max_notional_reg) begin
                            reason_next = REASON_NOTIONAL;
                        end else if (ref_present_reg &&
                                     (px_scaled < band_lo || px_scaled > band_hi)) begin
                            reason_next = REASON_BAND;
                        end
                    end
                end
            end
            KIND_FILL: begin
                pos_next = pos_sat;
                if (pos_mag > POS_W'(max_position_reg)) begin
                    kill_latched_next = 1'b1;
                end
            end
            KIND_MID: begin
                ref_present_next = mid_valid_reg;
                ref_mid_next     = mid_valid_reg ? mid_price_reg : '0;
            end
            default: begin
                token_next     = capacity_reg;
                last_time_next = '0;
                pos_next       = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rate_reg      <= MAX_RATE_RESET;
            max_notional_reg  <= MAX_NOTIONAL_RESET;
            band_bps_reg      <= BAND_BPS_RESET;
            max_position_reg  <= MAX_POSITION_RESET;
            kill_at_start_reg <= 1'b0;
            capacity_reg      <= CAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_RATE: begin
                    max_rate_reg <= cfg_wdata[RATE_W-1:0];
                    // hold capacity precomputed so the state loop carries no extra multiply
                    capacity_reg <= TOKEN_W'(cfg_wdata[RATE_W-1:0]) * TOKEN_UNIT_L;
                end
                REG_MAX_NOTIONAL:  max_notional_reg  <= cfg_wdata[NOTIONAL_W-1:0];
                REG_BAND_BPS:      band_bps_reg      <= cfg_wdata[BPS_W-1:0];
                REG_MAX_POSITION:  max_position_reg  <= cfg_wdata[MAXPOS_W-1:0];
                REG_KILL_AT_START: kill_at_start_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            token_reg        <= CAP_RESET;
            last_time_reg    <= '0;
            pos_reg          <= '0;
            ref_mid_reg      <= '0;
            ref_present_reg  <= 1'b0;
            kill_latched_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg      <= 1'b1;
                token_reg        <= token_next;
                last_time_reg    <= last_time_next;
                pos_reg          <= pos_next;
                ref_mid_reg      <= ref_mid_next;
                ref_present_reg  <= ref_present_next;
                kill_latched_reg <= kill_latched_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg      <= kind_t'(s_tuser);
            side_reg      <= s_tdata[0];
            price_reg     <= s_tdata[32:1];
            qty_reg       <= s_tdata[64:33];
            ts_reg        <= s_tdata[127:65];
            mid_price_reg <= s_tdata[159:128];
            mid_valid_reg <= s_tdata[160];
        end
        if (advance) begin
            out_data_reg <= {3'b000,
                             kill_latched_next | kill_at_start_reg,
                             pos_next,
                             reason_next,
                             reason_next == REASON_OK};
        end
    end

endmodule

// ----- rtl/core/ptrg_checker.sv -----
// Port-level checks for the pre-trade risk gate, bound to the top level.
module ptrg_checker
    import ptrg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata
);

    // no result may be offered in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // accepted flag agrees with the reason code
    a_accept_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == REASON_OK)))
        else $error("accepted flag disagrees with reason");

    // reason is one of the defined outcomes and padding stays clear
    a_reason_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= REASON_BAND) && (m_tdata[71:69] == 3'b000))
        else $error("undefined reason code or dirty padding");

endmodule

bind pre_trade_risk_gate_unit ptrg_checker u_ptrg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/pre_trade_risk_gate_unit_tb.sv -----
// Self-checking testbench for the pre-trade risk gate: directed and random items, checked in order.
module pre_trade_risk_gate_unit_tb
    import ptrg_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ONE_ORDER   = 64'd1000000000;
    localparam longint      LONG_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      LONG_MIN    = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          MAX_SHOWN   = 10;

    typedef struct packed {
        logic                accepted;
        reason_t             reason;
        logic signed [63:0]  net_position;
        logic                kill_active;
    } verdict_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic [1:0]              s_tuser   = KIND_ORDER;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = REG_MAX_RATE;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    pre_trade_risk_gate_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gate state as predicted from the accepted transfers
    logic [RATE_W-1:0]     lim_rate;
    logic [NOTIONAL_W-1:0] lim_notional;
    logic [BPS_W-1:0]      lim_band;
    logic [MAXPOS_W-1:0]   lim_pos;
    logic                  kill_sw;
    logic [63:0]           bucket;
    logic [TS_W-1:0]       last_ts;
    longint                pos_net;
    longint                mid_ref;
    logic                  mid_on;
    logic                  kill_lat;

    verdict_t verdict_q[$];
    int       mismatches = 0;
    int       cycle_cnt  = 0;

    // Stimulus-side view used to aim prices and timestamps
    int              gen_band  = 100;
    int              cur_mid   = 0;
    logic            mid_on_tb = 1'b0;
    logic [TS_W-1:0] ts_now    = '0;
    int              burst_left = 0;

    always @(posedge aclk) begin : gate_model
        verdict_t    want;
        verdict_t    got;
        reason_t     why;
        longint      px;
        longint      qty;
        longint      delta;
        longint      bw;
        longint      lo;
        longint      hi;
        logic [63:0] dt;
        logic [63:0] cap;
        logic [63:0] mag;
        logic [63:0] notl;
        logic [TS_W-1:0] ts;
        if (!aresetn) begin
            lim_rate     = MAX_RATE_RESET;
            lim_notional = MAX_NOTIONAL_RESET;
            lim_band     = BAND_BPS_RESET;
            lim_pos      = MAX_POSITION_RESET;
            kill_sw      = 1'b0;
            bucket       = MAX_RATE_RESET * ONE_ORDER;
            last_ts      = '0;
            pos_net      = 0;
            mid_ref      = 0;
            mid_on       = 1'b0;
            kill_lat     = 1'b0;
            verdict_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAX_RATE:      lim_rate     = cfg_wdata[RATE_W-1:0];
                    REG_MAX_NOTIONAL:  lim_notional = cfg_wdata[NOTIONAL_W-1:0];
                    REG_BAND_BPS:      lim_band     = cfg_wdata[BPS_W-1:0];
                    REG_MAX_POSITION:  lim_pos      = cfg_wdata[MAXPOS_W-1:0];
                    REG_KILL_AT_START: kill_sw      = cfg_wdata[0];
                    default: ;
                endcase
            end

            // Results trail their inputs through the input and result registers: pop before push
            if (m_tvalid && m_tready) begin
                got.accepted     = m_tdata[0];
                got.reason       = reason_t'(m_tdata[3:1]);
                got.net_position = m_tdata[67:4];
                got.kill_active  = m_tdata[68];
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result transfer:",
                                 " acc=%0b reason=%0d pos=%0d kill=%0b",
                                 got.accepted, got.reason, got.net_position, got.kill_active);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.accepted !== want.accepted || got.reason !== want.reason ||
                        got.net_position !== want.net_position ||
                        got.kill_active !== want.kill_active) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: exp acc=%0b reason=%0d pos=%0d kill=%0b,",
                                     want.accepted, want.reason, want.net_position,
                                     want.kill_active,
                                     " got acc=%0b reason=%0d pos=%0d kill=%0b",
                                     got.accepted, got.reason,
                                     got.net_position, got.kill_active);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                px  = longint'($signed(s_tdata[32:1]));
                qty = longint'($signed(s_tdata[64:33]));
                ts  = s_tdata[127:65];
                why = REASON_OK;
                case (kind_t'(s_tuser))
                    KIND_ORDER: begin
                        if (kill_sw || kill_lat)
                            why = REASON_KILL;
                        else if (qty <= 0 || px <= 0)
                            why = REASON_INVALID;
                        else begin
                            if (last_ts != 0 && ts > last_ts) begin
                                dt = 64'(ts - last_ts);
                                if (dt > ONE_ORDER)
                                    dt = ONE_ORDER;
                                cap    = lim_rate * ONE_ORDER;
                                bucket = bucket + dt * lim_rate;
                                if (bucket > cap)
                                    bucket = cap;
                            end
                            last_ts = ts;
                            if (bucket < ONE_ORDER)
                                why = REASON_RATE;
                            else begin
                                // tokens are spent even if a later check rejects
                                bucket = bucket - ONE_ORDER;
                                notl   = px * qty;
                                bw     = longint'(lim_band);
                                lo     = mid_ref * (10000 - bw);
                                hi     = mid_ref * (10000 + bw);
                                if (notl > {1'b0, lim_notional})
                                    why = REASON_NOTIONAL;
                                else if (mid_on && (px * 10000 < lo || px * 10000 > hi))
                                    why = REASON_BAND;
                            end
                        end
                    end
                    KIND_FILL: begin
                        delta = s_tdata[0] ? -qty : qty;
                        if (delta > 0 && pos_net > LONG_MAX - delta)
                            pos_net = LONG_MAX;
                        else if (delta < 0 && pos_net < LONG_MIN - delta)
                            pos_net = LONG_MIN;
                        else
                            pos_net = pos_net + delta;
                        mag = (pos_net < 0) ? -pos_net : pos_net;
                        if (mag > {16'b0, lim_pos})
                            kill_lat = 1'b1;
                    end
                    KIND_MID: begin
                        mid_on = s_tdata[160];
                        if (mid_on)
                            mid_ref = longint'($signed(s_tdata[159:128]));
                        else
                            mid_ref = 0;
                    end
                    default: begin
                        // soft reset keeps the kill latch and the reference
                        bucket  = lim_rate * ONE_ORDER;
                        last_ts = '0;
                        pos_net = 0;
                    end
                endcase
                want.accepted     = (why == REASON_OK);
                want.reason       = why;
                want.net_position = pos_net;
                want.kill_active  = kill_lat || kill_sw;
                verdict_q.push_back(want);
            end
        end
    end

    // Receiver back-pressure: the pattern changes at regular intervals to one picked at random
    int rx_mode = 0;
    int rx_tick = 0;
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 128 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= (rx_tick % 16 < 3);
        endcase
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("pre_trade_risk_gate_unit_tb NOT OK");
            $finish;
        end
    end

    // Send one item; bursts of random length with random gaps in between
    task automatic send_item(kind_t k, logic side, logic [31:0] px, logic [31:0] qty,
                             logic [TS_W-1:0] ts, logic [31:0] mid, logic midv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'b0, midv, mid, ts, qty, px, side};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the sender until every expected result has come
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(logic [RATE_W-1:0] rate, logic [NOTIONAL_W-1:0] notional,
                              logic [BPS_W-1:0] band, logic [MAXPOS_W-1:0] maxpos,
                              logic kill);
        logic [CFG_DATA_W-1:0]  vals [5];
        logic [CFG_INDEX_W-1:0] idx  [5];
        settle();
        idx  = '{REG_MAX_RATE, REG_MAX_NOTIONAL, REG_BAND_BPS, REG_MAX_POSITION,
                 REG_KILL_AT_START};
        vals = '{CFG_DATA_W'(rate), CFG_DATA_W'(notional), CFG_DATA_W'(band),
                 CFG_DATA_W'(maxpos), CFG_DATA_W'(kill)};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        gen_band = int'(band);
    endtask

    function automatic logic [MAXPOS_W-1:0] big_position_limit();
        return 48'h0100_0000_0000 + {16'($urandom_range(0, 16'h7EFF)), $urandom};
    endfunction

    // Mostly well-formed orders aimed at the band and bucket, plus fills,
    // mid updates, soft resets and a share of fully random noise
    task automatic run_random(int n, int unsigned dt_max);
        int          ch;
        int          r;
        int          px;
        int          span;
        logic [31:0] qty;
        for (int i = 0; i < n; i++) begin
            ch = $urandom_range(0, 99);
            if (ch < 5) begin
                send_item(kind_t'($urandom_range(0, 3)), 1'($urandom), $urandom, $urandom,
                          TS_W'({$urandom, $urandom}), $urandom, 1'($urandom));
            end else if (ch < 60) begin
                if (mid_on_tb && $urandom_range(0, 3) != 0) begin
                    span = cur_mid / 10000 * gen_band + cur_mid % 10000 * gen_band / 10000 + 2;
                    px   = cur_mid - span + $urandom_range(0, 2 * span);
                end else if ($urandom_range(0, 99) == 0)
                    px = $urandom;
                else
                    px = $urandom_range(1, 1000000);
                r = $urandom_range(0, 99);
                if (r < 3)
                    qty = -$urandom_range(0, 1000);
                else if (r < 13)
                    qty = $urandom_range(1, 32'h7FFF_FFFF);
                else
                    qty = $urandom_range(1, 2000);
                r = $urandom_range(0, 99);
                if (r < 8)
                    ;
                else if (r < 12)
                    ts_now = ts_now - $urandom_range(1, 1000);
                else if (r < 80)
                    ts_now = ts_now + $urandom_range(1, dt_max);
                else if (r < 95)
                    ts_now = ts_now + $urandom_range(1, 1000000000);
                else if (r < 98)
                    ts_now = ts_now + 63'd2000000000;
                else
                    ts_now = TS_W'({$urandom, $urandom});
                send_item(KIND_ORDER, 1'($urandom), px, qty, ts_now, $urandom, 1'($urandom));
            end else if (ch < 78) begin
                qty = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 5000);
                send_item(KIND_FILL, 1'($urandom), $urandom, qty, TS_W'({$urandom, $urandom}),
                          $urandom, 1'($urandom));
            end else if (ch < 93) begin
                mid_on_tb = ($urandom_range(0, 4) != 0);
                cur_mid   = $urandom_range(1, 1000000);
                send_item(KIND_MID, 1'($urandom), $urandom, $urandom,
                          TS_W'({$urandom, $urandom}), cur_mid, mid_on_tb);
            end else begin
                send_item(KIND_SOFT_RST, 1'($urandom), $urandom, $urandom,
                          TS_W'({$urandom, $urandom}), $urandom, 1'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        // reset settings: full bucket, band of 100 bps
        send_item(KIND_ORDER, 1'b0, 32'd100, 32'd10, 63'd0, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd0, 32'd10, 63'd10, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd100, 32'd0, 63'd20, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'h8000_0000, 32'd1, 63'd30, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd100, 32'h8000_0000, 63'd40, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd1000, 32'd0, 1'b0);
        send_item(KIND_MID, 1'b0, 32'd0, 32'd0, 63'd0, 32'd1000, 1'b1);
        // band edges are inclusive
        send_item(KIND_ORDER, 1'b0, 32'd1000, 32'd5, 63'd2000, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd1010, 32'd5, 63'd3000, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd1011, 32'd5, 63'd4000, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd990, 32'd5, 63'd5000, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd989, 32'd5, 63'd6000, 32'd0, 1'b0);
        // clearing the reference also zeroes the mid
        send_item(KIND_MID, 1'b1, 32'd0, 32'd0, 63'd0, 32'd12345, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd1011, 32'd5, 63'd7000, 32'd0, 1'b0);
        send_item(KIND_FILL, 1'b0, 32'd0, 32'd500, 63'd0, 32'd0, 1'b0);
        send_item(KIND_FILL, 1'b1, 32'd0, 32'd800, 63'd0, 32'd0, 1'b0);
        send_item(KIND_FILL, 1'b1, 32'd0, -32'd200, 63'd0, 32'd0, 1'b0);
        send_item(KIND_SOFT_RST, 1'b0, 32'd0, 32'd0, 63'd0, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd5, 32'd5, {TS_W{1'b1}}, 32'd0, 1'b0);
        // negative reference puts the whole band below zero
        send_item(KIND_MID, 1'b0, 32'd0, 32'd0, 63'd0, -32'd5, 1'b1);
        send_item(KIND_ORDER, 1'b0, 32'd1, 32'd1, {TS_W{1'b1}}, 32'd0, 1'b0);
        send_item(KIND_MID, 1'b0, 32'd0, 32'd0, 63'd0, 32'd0, 1'b0);
        // software kill blocks orders and shows on fills
        set_config(MAX_RATE_RESET, MAX_NOTIONAL_RESET, BAND_BPS_RESET, MAX_POSITION_RESET, 1'b1);
        send_item(KIND_ORDER, 1'b0, 32'd100, 32'd1, 63'd9000, 32'd0, 1'b0);
        send_item(KIND_FILL, 1'b0, 32'd0, 32'd1, 63'd0, 32'd0, 1'b0);
        mid_on_tb = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (2) begin
            set_config(RATE_W'($urandom_range(500, 2000)),
                       NOTIONAL_W'({$urandom_range(0, 15), $urandom}),
                       BPS_W'($urandom_range(1, 500)), big_position_limit(), 1'b0);
            run_random(200, 2000000);
        end
    endtask

    task automatic test_rate_limit();
        int rate;
        repeat (2) begin
            rate = $urandom_range(1, 4);
            set_config(RATE_W'(rate), 63'd100000000000, BPS_W'($urandom_range(1, 2000)),
                       big_position_limit(), 1'b0);
            run_random(120, 1000000000 / rate);
        end
    endtask

    task automatic test_rate_extremes();
        // a lowered rate leaves the bucket as it was until the next refill
        set_config(20'd0, MAX_NOTIONAL_RESET, BAND_BPS_RESET, big_position_limit(), 1'b0);
        run_random(60, 1000000);
        set_config({RATE_W{1'b1}}, MAX_NOTIONAL_RESET, BAND_BPS_RESET,
                   48'h8000_0000_0000, 1'b0);
        run_random(80, 1000);
    endtask

    task automatic test_limit_extremes();
        set_config(MAX_RATE_RESET, 63'd0, 14'd10000, big_position_limit(), 1'b0);
        run_random(80, 2000000);
        set_config(MAX_RATE_RESET, 63'h4000_0000_0000_0000, 14'd0, big_position_limit(), 1'b0);
        run_random(80, 2000000);
    endtask

    task automatic test_kill_switch();
        set_config(RATE_W'($urandom_range(1, 2000)), MAX_NOTIONAL_RESET,
                   BPS_W'($urandom_range(0, 10000)), big_position_limit(), 1'b1);
        run_random(40, 2000000);
    endtask

    // The latch survives soft reset, so this runs last
    task automatic test_kill_latch();
        set_config(MAX_RATE_RESET, MAX_NOTIONAL_RESET, BAND_BPS_RESET, 48'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd100, 32'd1, ts_now + 1, 32'd0, 1'b0);
        send_item(KIND_FILL, 1'b0, 32'd0, 32'd1, 63'd0, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd100, 32'd1, ts_now + 2, 32'd0, 1'b0);
        send_item(KIND_SOFT_RST, 1'b0, 32'd0, 32'd0, 63'd0, 32'd0, 1'b0);
        send_item(KIND_ORDER, 1'b0, 32'd100, 32'd1, ts_now + 3, 32'd0, 1'b0);
        run_random(60, 2000000);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_mix();
        test_rate_limit();
        test_rate_extremes();
        test_limit_extremes();
        test_kill_switch();
        test_kill_latch();
        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("pre_trade_risk_gate_unit_tb OK");
        end else begin
            $display("pre_trade_risk_gate_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ptrg_pkg.sv
rtl/core/pre_trade_risk_gate_unit.sv
rtl/core/ptrg_checker.sv
verif/pre_trade_risk_gate_unit_tb.sv
